>>> src/ppst_pkg.sv
// Shared types, constants and the arctangent lookup table for the pure pursuit steering block.
`default_nettype none
package ppst_pkg;

  localparam int MAX_WAYPOINTS = 1024;
  localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
  localparam int LEN_W         = IDX_W + 1;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STEPS  = 30;
  localparam int ALPHA_SH      = 32 - ANGLE_BITS;

  localparam logic [32:0] MAX_DIST_CM  = 33'd10000000;
  localparam logic [48:0] MAX_DIST_SQ  = 49'd100000000000000;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WAYPOINTS);

  localparam logic OP_WAYPOINT = 1'b0;
  localparam logic OP_FIX      = 1'b1;

  localparam logic [2:0] CFG_PATH_LENGTH = 3'd0;
  localparam logic [2:0] CFG_LOOK_OFFSET = 3'd1;
  localparam logic [2:0] CFG_AXLE_LENGTH = 3'd2;
  localparam logic [2:0] CFG_SPEED       = 3'd3;

  typedef struct packed {
    logic                    op;
    logic [9:0]              waypoint_index;
    logic signed [31:0]      east_cm;
    logic signed [31:0]      north_cm;
    logic signed [15:0]      heading_angle;
    logic                    fix_valid;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        speed_cmd;
    logic signed [15:0] rudder_cmd;
    logic signed [15:0] steer_angle;
    logic [9:0]         nearest_index;
    logic [9:0]         lookahead_index;
    logic               no_fix;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic vec;   // 1 vectoring, 0 rotation
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [33:0] z;
    logic [5:0]         sh;
  } cor_rsp_t;

  // atan(2^-i) with pi = 2^31
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/pure_pursuit_steering.sv
// Top level: waypoint table, nearest-waypoint scan and steering sequencer.
//
//  channel | ports                          | transfer
//  in      | in_valid, in_ready, in_data    | waypoint write or position fix
//  out     | out_valid, out_ready, out_data | one steering result per fix
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, never stalls
//
// A fix scans the table entries, one read per cycle from the table port, then
// makes up to three passes of the shared CORDIC (normalize, then 30 steps).
// A fix without a valid position skips the scan and the CORDIC.
// Synchronous reset; no clearing pass. A new item is taken while a result
// still waits on out; a busy out only holds the finished fix.
`default_nettype none
module pure_pursuit_steering
  import ppst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SCAN  = 12'b000000000010,
    S_LOOK  = 12'b000000000100,
    S_LDATA = 12'b000000001000,
    S_VEC1  = 12'b000000010000,
    S_W1    = 12'b000000100000,
    S_ALPHA = 12'b000001000000,
    S_SIN   = 12'b000010000000,
    S_W2    = 12'b000100000000,
    S_VEC2  = 12'b001000000000,
    S_W3    = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r;

  // configuration
  logic [LEN_W-1:0] path_len_r;
  logic [9:0]       look_off_r;
  logic [9:0]       axle_r;
  logic [15:0]      speed_r;

  // fix and progress
  logic signed [31:0] fe_r, fn_r;
  logic signed [15:0] hdg_r;
  logic [IDX_W-1:0]   prog_r;
  logic               nofix_r;

  // scan
  logic [IDX_W-1:0] iss_r;
  logic             issuing_r;
  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] i1_r, i2_r, i3_r;
  logic             ok2_r, ok3_r;
  logic [23:0]      ae2_r, an2_r;
  logic [47:0]      sqe_r, sqn_r;
  logic [48:0]      best_d_r;
  logic [IDX_W-1:0] best_r;
  logic             found_r;

  // steering
  logic [IDX_W-1:0]   look_r;
  logic signed [32:0] dxl_r, dyl_r;
  logic               zero_r;
  logic signed [63:0] mag1_r;
  logic [5:0]         sh1_r;
  logic signed [33:0] bear_r;
  logic signed [35:0] alpha_r;
  logic signed [63:0] num_r;
  logic signed [33:0] steer_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  // memory port
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [63:0]      ram_rdata;

  cor_req_t           cor_req;
  cor_rsp_t           cor_rsp;
  logic signed [63:0] cor_x0, cor_y0;

  logic in_acc;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && (in_data.op == OP_WAYPOINT);

  // clamped path length
  logic [LEN_W-1:0] len_c;
  always_comb begin
    if (path_len_r == '0) begin
      len_c = LEN_W'(1);
    end else if (path_len_r > MAX_LEN) begin
      len_c = MAX_LEN;
    end else begin
      len_c = path_len_r;
    end
  end

  // scan datapath
  logic signed [31:0] rd_e, rd_n;
  logic signed [32:0] dxe_c, dyn_c;
  logic [32:0]        ae_c, an_c;
  logic [48:0]        d_c;
  logic               upd_c;
  logic               last_iss_c;

  assign rd_e  = ram_rdata[63:32];
  assign rd_n  = ram_rdata[31:0];
  assign dxe_c = 33'(rd_e) - 33'(fe_r);
  assign dyn_c = 33'(rd_n) - 33'(fn_r);
  assign ae_c  = dxe_c[32] ? 33'(-dxe_c) : 33'(dxe_c);
  assign an_c  = dyn_c[32] ? 33'(-dyn_c) : 33'(dyn_c);
  assign d_c   = {1'b0, sqe_r} + {1'b0, sqn_r};
  // ties go to the later entry
  assign upd_c = v3_r && ok3_r && (d_c <= MAX_DIST_SQ) && (!found_r || d_c <= best_d_r);
  assign last_iss_c = ({1'b0, iss_r} == len_c - LEN_W'(2));

  logic [LEN_W-1:0] look_sum_c, len_m1_c;
  logic [IDX_W-1:0] look_c;
  assign look_sum_c = {1'b0, best_r} + LEN_W'(look_off_r);
  assign len_m1_c   = len_c - LEN_W'(1);
  assign look_c     = (look_sum_c <= len_m1_c) ? look_sum_c[IDX_W-1:0] : len_m1_c[IDX_W-1:0];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = iss_r;
    if (state_r == S_SCAN && issuing_r) begin
      ram_re = 1'b1;
    end else if (state_r == S_LOOK) begin
      ram_re    = 1'b1;
      ram_raddr = look_c;
    end
  end

  // alpha: heading minus bearing, wrapped, rounded to the angle grid
  localparam logic signed [35:0] PI36   = 36'sd1 <<< 31;
  localparam logic signed [35:0] TWO_PI = 36'sd1 <<< 32;
  localparam logic signed [35:0] HALF36 = 36'sd1 <<< 30;
  logic signed [35:0] a0_c, a1_c, a2_c, alpha_c;
  assign a0_c = (36'(hdg_r) <<< 16) - 36'(bear_r);
  always_comb begin
    a1_c = a0_c;
    if (a1_c > PI36) begin
      a1_c = a1_c - TWO_PI;
    end
    if (a1_c < -PI36) begin
      a1_c = a1_c + TWO_PI;
    end
  end
  assign a2_c    = (a1_c + (36'sd1 <<< (ALPHA_SH - 1))) >>> ALPHA_SH;
  assign alpha_c = a2_c <<< ALPHA_SH;

  logic signed [63:0] den_c;
  assign den_c = (sh1_r >= 6'd20) ? (mag1_r >>> (sh1_r - 6'd20))
                                  : (mag1_r <<< (6'd20 - sh1_r));

  always_comb begin
    cor_req.start = 1'b0;
    cor_req.vec   = 1'b1;
    cor_x0        = 64'(dyl_r);
    cor_y0        = 64'(dxl_r);
    unique case (state_r)
      S_VEC1: cor_req.start = 1'b1;
      S_SIN: begin
        cor_req.start = 1'b1;
        cor_req.vec   = 1'b0;
        cor_x0        = 64'({axle_r, 21'b0});
        cor_y0        = '0;
      end
      S_VEC2: begin
        cor_req.start = 1'b1;
        cor_x0        = den_c;
        cor_y0        = num_r;
      end
      default: ;
    endcase
  end

  // result formatting
  logic signed [35:0] st16_c, rud_c;
  out_item_t          res_c;
  always_comb begin
    st16_c = (36'(steer_r) + 36'sd32768) >>> 16;
    rud_c  = (-36'(steer_r) + 36'sd16384) >>> 15;
    res_c.speed_cmd       = speed_r;
    res_c.steer_angle     = st16_c[15:0];
    res_c.nearest_index   = prog_r;
    res_c.lookahead_index = look_r;
    res_c.no_fix          = 1'b0;
    if (rud_c > 36'sd32767) begin
      res_c.rudder_cmd = 16'sh7fff;
    end else if (rud_c < -36'sd32768) begin
      res_c.rudder_cmd = 16'sh8000;
    end else begin
      res_c.rudder_cmd = rud_c[15:0];
    end
    if (nofix_r) begin
      res_c.speed_cmd       = '0;
      res_c.rudder_cmd      = '0;
      res_c.steer_angle     = '0;
      res_c.lookahead_index = '0;
      res_c.no_fix          = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_len_r <= LEN_W'(1);
      look_off_r <= 10'd10;
      axle_r     <= 10'd30;
      speed_r    <= 16'd13107;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATH_LENGTH: path_len_r <= cfg_data[LEN_W-1:0];
        CFG_LOOK_OFFSET: look_off_r <= cfg_data[9:0];
        CFG_AXLE_LENGTH: axle_r     <= cfg_data[9:0];
        CFG_SPEED:       speed_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan pipeline payload
  always_ff @(posedge clk) begin
    i1_r  <= iss_r;
    i2_r  <= i1_r;
    i3_r  <= i2_r;
    ok2_r <= (ae_c <= MAX_DIST_CM) && (an_c <= MAX_DIST_CM);
    ok3_r <= ok2_r;
    ae2_r <= ae_c[23:0];
    an2_r <= an_c[23:0];
    sqe_r <= ae2_r * ae2_r;
    sqn_r <= an2_r * an2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prog_r      <= '0;
      issuing_r   <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      nofix_r     <= 1'b0;
    end else begin
      v1_r <= (state_r == S_SCAN) && issuing_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.op == OP_FIX) begin
            fe_r    <= in_data.east_cm;
            fn_r    <= in_data.north_cm;
            hdg_r   <= in_data.heading_angle;
            nofix_r <= !in_data.fix_valid;
            if (in_data.fix_valid) begin
              iss_r     <= prog_r;
              issuing_r <= ({1'b0, prog_r} + LEN_W'(1) < len_c);
              best_r    <= prog_r;
              found_r   <= 1'b0;
              state_r   <= S_SCAN;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (issuing_r) begin
            if (last_iss_c) begin
              issuing_r <= 1'b0;
            end else begin
              iss_r <= iss_r + IDX_W'(1);
            end
          end
          if (upd_c) begin
            found_r  <= 1'b1;
            best_d_r <= d_c;
            best_r   <= i3_r;
          end
          if (!issuing_r && !v1_r && !v2_r && !v3_r) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          look_r  <= look_c;
          prog_r  <= best_r;
          state_r <= S_LDATA;
        end
        S_LDATA: begin
          dxl_r   <= dxe_c;
          dyl_r   <= dyn_c;
          zero_r  <= (dxe_c == 33'sd0) && (dyn_c == 33'sd0);
          state_r <= S_VEC1;
        end
        S_VEC1: state_r <= S_W1;
        S_W1: begin
          if (cor_rsp.done) begin
            mag1_r  <= cor_rsp.x;
            sh1_r   <= cor_rsp.sh;
            bear_r  <= cor_rsp.z;
            state_r <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          alpha_r <= alpha_c;
          if (zero_r || alpha_c >= HALF36 || alpha_c <= -HALF36) begin
            if (alpha_c > 36'sd0) begin
              steer_r <= 34'sd1 <<< 30;
            end else if (alpha_c < 36'sd0) begin
              steer_r <= -(34'sd1 <<< 30);
            end else begin
              steer_r <= '0;
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_SIN;
          end
        end
        S_SIN: state_r <= S_W2;
        S_W2: begin
          if (cor_rsp.done) begin
            num_r   <= cor_rsp.y;
            state_r <= S_VEC2;
          end
        end
        S_VEC2: state_r <= S_W3;
        S_W3: begin
          if (cor_rsp.done) begin
            steer_r <= cor_rsp.z;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r <= res_c;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ppst_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.waypoint_index),
    .wdata ({in_data.east_cm, in_data.north_cm}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppst_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (alpha_r[33:0]),
    .rsp   (cor_rsp)
  );

endmodule
`default_nettype wire

>>> src/ppst_ram.sv
// Waypoint table: one write port, one registered read port, {east, north} per entry.
`default_nettype none
module ppst_ram
  import ppst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [63:0]      wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output logic [63:0]           rdata
);

  logic [63:0] mem [MAX_WAYPOINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/ppst_cordic.sv
// Shared iterative CORDIC: vectoring (atan2, magnitude) and rotation, one step per cycle.
`default_nettype none
module ppst_cordic
  import ppst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cor_req_t           req,
  input  wire logic signed [63:0] x0,
  input  wire logic signed [63:0] y0,
  input  wire logic signed [33:0] z0,
  output cor_rsp_t                rsp
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_NORM = 3'b010,
    U_ITER = 3'b100
  } ustate_t;

  localparam logic signed [63:0] NORM_LIM = 64'sd1 <<< 57;
  localparam logic signed [33:0] HALF_PI  = 34'sd1 <<< 30;

  ustate_t            st_r;
  logic               vec_r;
  logic               done_r;
  logic signed [63:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [5:0]         sh_r;
  logic [4:0]         it_r;

  logic signed [63:0] xs_c, ys_c;
  logic signed [33:0] at_c;
  logic               dir_c;
  logic               small_c;

  assign xs_c    = x_r >>> it_r;
  assign ys_c    = y_r >>> it_r;
  assign at_c    = 34'(atan_lut(it_r));
  // rotate counterclockwise: vectoring when y <= 0, rotation when z >= 0
  assign dir_c   = vec_r ? (y_r > 64'sd0) : (z_r >= 34'sd0);
  assign small_c = (x_r < NORM_LIM) && (x_r > -NORM_LIM) &&
                   (y_r < NORM_LIM) && (y_r > -NORM_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        U_IDLE: begin
          if (req.start) begin
            vec_r <= req.vec;
            x_r   <= x0;
            y_r   <= y0;
            sh_r  <= '0;
            it_r  <= '0;
            if (req.vec) begin
              z_r <= '0;
              if (x0 == 64'sd0 && y0 == 64'sd0) begin
                done_r <= 1'b1;
              end else begin
                st_r <= U_NORM;
              end
            end else begin
              z_r  <= z0;
              st_r <= U_ITER;
            end
          end
        end
        U_NORM: begin
          if (small_c) begin
            x_r  <= x_r <<< 1;
            y_r  <= y_r <<< 1;
            sh_r <= sh_r + 6'd1;
          end else begin
            // fold the left half plane by a quarter turn
            if (x_r < 64'sd0) begin
              if (y_r >= 64'sd0) begin
                x_r <= y_r;
                y_r <= -x_r;
                z_r <= HALF_PI;
              end else begin
                x_r <= -y_r;
                y_r <= x_r;
                z_r <= -HALF_PI;
              end
            end
            st_r <= U_ITER;
          end
        end
        U_ITER: begin
          if (dir_c == vec_r) begin
            // vectoring with y > 0: clockwise; rotation with z < 0: clockwise
            x_r <= x_r + ys_c;
            y_r <= y_r - xs_c;
            z_r <= vec_r ? z_r + at_c : z_r + at_c;
          end else begin
            x_r <= x_r - ys_c;
            y_r <= y_r + xs_c;
            z_r <= z_r - at_c;
          end
          if (it_r == 5'(CORDIC_STEPS - 1)) begin
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end else begin
            it_r <= it_r + 5'd1;
          end
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;
  assign rsp.z    = z_r;
  assign rsp.sh   = sh_r;

endmodule
`default_nettype wire

>>> src/ppst_checker.sv
// Port-level assertions for the pure pursuit steering block, bound to the top level.
`default_nettype none
module ppst_checker
  import ppst_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_nofix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_fix |->
      out_data.speed_cmd == 16'd0 && out_data.rudder_cmd == 16'sd0 &&
      out_data.steer_angle == 16'sd0 && out_data.lookahead_index == 10'd0)
    else $error("no-fix result carries commands");

  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.steer_angle <= 16'sd16384 && out_data.steer_angle >= -16'sd16384)
    else $error("steering angle beyond quarter turn");

  a_rudder_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.steer_angle > 16'sd0 |-> out_data.rudder_cmd <= 16'sd0)
    else $error("rudder not opposite to steering");

endmodule

bind pure_pursuit_steering ppst_checker u_ppst_checker (.*);
`default_nettype wire
